// ===== src/lbsel_pkg.sv =====
// shared constants, codes and types for the server load balancer selector
package lbsel_pkg;

  // default sizes
  localparam int MAX_SERVERS_DEF = 8;
  localparam int COUNT_BITS_DEF  = 16;

  // fixed field widths
  localparam int TYPE_W    = 3;
  localparam int ID_W      = 16;
  localparam int CNT_OUT_W = 16;
  localparam int ST_W      = 2;

  // request kinds
  localparam logic [TYPE_W-1:0] REQ_ADD        = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_REMOVE     = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_PICK       = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_CONNECT    = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_DISCONNECT = 3'd4;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

  // balance modes
  localparam logic MODE_RR = 1'b0;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

endpackage

// ===== src/server_load_balancer_selector.sv =====
// server table with round-robin and least-connections pick, one shared scan unit
//
//  channel | direction | beat contents
//  cfg     | in        | cfg_balance_mode (0 round-robin, 1 least-connections)
//  in      | in        | in_req_type, in_server_id
//  out     | out       | out_chosen_id, out_conn_count, out_status
//
// add, unknown kinds and requests on an empty table load the result register on accept;
// a round-robin pick reads only the entry under the pointer; remove, least-connections
// pick, connect and disconnect scan all N table entries, N the number of entries. the
// next beat is taken once the result has moved into the output register. the scan
// reads one table entry per cycle through the single read port, and remove writes
// back through the single write port behind it. in_ready is high only while the
// sequencer is idle.
// a finished result waits in the output register while the next beat is taken.
// synchronous active-low reset empties the table and clears the pointer and mode.
module server_load_balancer_selector #(
  parameter int MAX_SERVERS = lbsel_pkg::MAX_SERVERS_DEF,
  parameter int COUNT_BITS  = lbsel_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_balance_mode,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lbsel_pkg::TYPE_W-1:0]  in_req_type,
  input  logic [lbsel_pkg::ID_W-1:0]    in_server_id,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lbsel_pkg::ID_W-1:0]    out_chosen_id,
  output logic [lbsel_pkg::CNT_OUT_W-1:0] out_conn_count,
  output logic [lbsel_pkg::ST_W-1:0]    out_status
);

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int TOT_W = $clog2(MAX_SERVERS + 1);
  localparam int IW    = lbsel_pkg::ID_W;
  localparam int OW    = lbsel_pkg::CNT_OUT_W;
  localparam int SW    = lbsel_pkg::ST_W;
  localparam int KW    = lbsel_pkg::TYPE_W;
  localparam int CW    = COUNT_BITS;

  // table memory
  logic [IW-1:0] ids_mem [MAX_SERVERS];
  logic [CW-1:0] cnt_mem [MAX_SERVERS];

  // control state
  lbsel_pkg::state_t state_r, state_nxt;
  logic             mode_r, mode_nxt;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic [IDX_W-1:0] rr_r, rr_nxt;
  logic             pv_r, pv_nxt;
  logic             out_valid_r, out_valid_nxt;

  // working registers
  logic [KW-1:0]    kind_r, kind_nxt;
  logic [IW-1:0]    id_r, id_nxt;
  logic [TOT_W-1:0] issue_r, issue_nxt;
  logic [TOT_W-1:0] end_r, end_nxt;
  logic [IDX_W-1:0] pidx_r, pidx_nxt;
  logic [TOT_W-1:0] wpos_r, wpos_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] hit_r, hit_nxt;
  logic [IW-1:0]    best_id_r, best_id_nxt;
  logic [CW-1:0]    best_cnt_r, best_cnt_nxt;
  logic [IW-1:0]    res_id_r, res_id_nxt;
  logic [CW-1:0]    res_cnt_r, res_cnt_nxt;
  logic [SW-1:0]    res_st_r, res_st_nxt;
  logic [IW-1:0]    out_id_r, out_id_nxt;
  logic [OW-1:0]    out_cnt_r, out_cnt_nxt;
  logic [SW-1:0]    out_st_r, out_st_nxt;

  // memory read data
  logic [IW-1:0] rd_id_r;
  logic [CW-1:0] rd_cnt_r;

  // memory ports
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic             wr_id_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IW-1:0]    wr_id;
  logic [CW-1:0]    wr_cnt;

  // helpers
  logic             accept;
  logic             issuing;
  logic [IDX_W-1:0] rr_best;
  logic [TOT_W-1:0] rr_next;
  logic [CW-1:0]    adj_cnt;

  assign cfg_ready      = 1'b1;
  assign in_ready       = (state_r == lbsel_pkg::S_IDLE);
  assign accept         = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_chosen_id  = out_id_r;
  assign out_conn_count = out_cnt_r;
  assign out_status     = out_st_r;

  // round-robin choice, wrapping a stale pointer to the first entry
  assign rr_best = (TOT_W'(rr_r) < total_r) ? rr_r : '0;
  assign rr_next = TOT_W'(rr_best) + TOT_W'(1);

  // scan read side
  assign issuing = (issue_r != end_r);
  assign rd_addr = issue_r[IDX_W-1:0];

  // saturating count adjust for connect and disconnect
  always_comb begin
    if (kind_r == lbsel_pkg::REQ_CONNECT) begin
      adj_cnt = (best_cnt_r == {CW{1'b1}}) ? best_cnt_r : best_cnt_r + CW'(1);
    end else begin
      adj_cnt = (best_cnt_r == '0) ? best_cnt_r : best_cnt_r - CW'(1);
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    total_nxt    = total_r;
    rr_nxt       = rr_r;
    pv_nxt       = 1'b0;
    kind_nxt     = kind_r;
    id_nxt       = id_r;
    issue_nxt    = issue_r;
    end_nxt      = end_r;
    pidx_nxt     = pidx_r;
    wpos_nxt     = wpos_r;
    found_nxt    = found_r;
    hit_nxt      = hit_r;
    best_id_nxt  = best_id_r;
    best_cnt_nxt = best_cnt_r;
    res_id_nxt   = res_id_r;
    res_cnt_nxt  = res_cnt_r;
    res_st_nxt   = res_st_r;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_id_en     = 1'b0;
    wr_addr      = '0;
    wr_id        = '0;
    wr_cnt       = '0;

    if (cfg_valid && cfg_ready) begin
      mode_nxt = cfg_balance_mode;
    end

    case (state_r)
      lbsel_pkg::S_IDLE: begin
        if (accept) begin
          kind_nxt  = in_req_type;
          id_nxt    = in_server_id;
          wpos_nxt  = '0;
          found_nxt = 1'b0;
          hit_nxt   = '0;
          res_id_nxt  = '0;
          res_cnt_nxt = '0;
          res_st_nxt  = lbsel_pkg::ST_OK;
          state_nxt   = lbsel_pkg::S_EMIT;
          case (in_req_type)
            lbsel_pkg::REQ_ADD: begin
              if (total_r >= TOT_W'(MAX_SERVERS)) begin
                res_st_nxt = lbsel_pkg::ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_id_en   = 1'b1;
                wr_addr    = total_r[IDX_W-1:0];
                wr_id      = in_server_id;
                total_nxt  = total_r + TOT_W'(1);
                res_id_nxt = in_server_id;
              end
            end
            lbsel_pkg::REQ_REMOVE, lbsel_pkg::REQ_PICK,
            lbsel_pkg::REQ_CONNECT, lbsel_pkg::REQ_DISCONNECT: begin
              if (total_r == '0) begin
                res_st_nxt = lbsel_pkg::ST_EMPTY;
              end else if (in_req_type == lbsel_pkg::REQ_PICK &&
                           mode_r == lbsel_pkg::MODE_RR) begin
                // fetch the single entry under the pointer
                issue_nxt = TOT_W'(rr_best);
                end_nxt   = rr_next;
                rr_nxt    = (rr_next >= total_r) ? '0 : rr_next[IDX_W-1:0];
                state_nxt = lbsel_pkg::S_SCAN;
              end else begin
                issue_nxt = '0;
                end_nxt   = total_r;
                state_nxt = lbsel_pkg::S_SCAN;
              end
            end
            default: begin
              res_st_nxt = lbsel_pkg::ST_OK;
            end
          endcase
        end
      end

      lbsel_pkg::S_SCAN: begin
        // issue one read per cycle
        if (issuing) begin
          rd_en     = 1'b1;
          issue_nxt = issue_r + TOT_W'(1);
          pv_nxt    = 1'b1;
          pidx_nxt  = rd_addr;
        end

        // look at the entry read last cycle
        if (pv_r) begin
          case (kind_r)
            lbsel_pkg::REQ_REMOVE: begin
              if (rd_id_r != id_r) begin
                wr_en    = 1'b1;
                wr_id_en = 1'b1;
                wr_addr  = wpos_r[IDX_W-1:0];
                wr_id    = rd_id_r;
                wr_cnt   = rd_cnt_r;
                wpos_nxt = wpos_r + TOT_W'(1);
              end
            end
            lbsel_pkg::REQ_PICK: begin
              if (mode_r == lbsel_pkg::MODE_RR || pidx_r == '0 || rd_cnt_r < best_cnt_r) begin
                best_id_nxt  = rd_id_r;
                best_cnt_nxt = rd_cnt_r;
              end
            end
            default: begin
              if (!found_r && rd_id_r == id_r) begin
                found_nxt    = 1'b1;
                hit_nxt      = pidx_r;
                best_cnt_nxt = rd_cnt_r;
              end
            end
          endcase
        end

        // scan finished
        if (!issuing && !pv_r) begin
          state_nxt   = lbsel_pkg::S_EMIT;
          res_id_nxt  = '0;
          res_cnt_nxt = '0;
          res_st_nxt  = lbsel_pkg::ST_OK;
          case (kind_r)
            lbsel_pkg::REQ_REMOVE: begin
              if (wpos_r == total_r) begin
                res_st_nxt = lbsel_pkg::ST_NOT_FOUND;
              end else begin
                total_nxt  = wpos_r;
                res_id_nxt = id_r;
                if (TOT_W'(rr_r) >= wpos_r) begin
                  rr_nxt = '0;
                end
              end
            end
            lbsel_pkg::REQ_PICK: begin
              res_id_nxt  = best_id_r;
              res_cnt_nxt = best_cnt_r;
            end
            default: begin
              if (!found_r) begin
                res_st_nxt = lbsel_pkg::ST_NOT_FOUND;
              end else begin
                wr_en       = 1'b1;
                wr_addr     = hit_r;
                wr_cnt      = adj_cnt;
                res_id_nxt  = id_r;
                res_cnt_nxt = adj_cnt;
              end
            end
          endcase
        end
      end

      lbsel_pkg::S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = lbsel_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = lbsel_pkg::S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_id_nxt    = out_id_r;
    out_cnt_nxt   = out_cnt_r;
    out_st_nxt    = out_st_r;
    if (state_r == lbsel_pkg::S_EMIT && (!out_valid_r || out_ready)) begin
      out_valid_nxt = 1'b1;
      out_id_nxt    = res_id_r;
      out_cnt_nxt   = OW'(res_cnt_r);
      out_st_nxt    = res_st_r;
    end
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_id_en) begin
        ids_mem[wr_addr] <= wr_id;
      end
      cnt_mem[wr_addr] <= wr_cnt;
    end
    if (rd_en) begin
      rd_id_r  <= ids_mem[rd_addr];
      rd_cnt_r <= cnt_mem[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbsel_pkg::S_IDLE;
      mode_r      <= 1'b0;
      total_r     <= '0;
      rr_r        <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      total_r     <= total_nxt;
      rr_r        <= rr_nxt;
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    id_r       <= id_nxt;
    issue_r    <= issue_nxt;
    end_r      <= end_nxt;
    pidx_r     <= pidx_nxt;
    wpos_r     <= wpos_nxt;
    found_r    <= found_nxt;
    hit_r      <= hit_nxt;
    best_id_r  <= best_id_nxt;
    best_cnt_r <= best_cnt_nxt;
    res_id_r   <= res_id_nxt;
    res_cnt_r  <= res_cnt_nxt;
    res_st_r   <= res_st_nxt;
    out_id_r   <= out_id_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_st_r   <= out_st_nxt;
  end

endmodule

// ===== src/lbsel_chk.sv =====
// port-level checker for the server load balancer selector, bound to the top level
module lbsel_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic                            cfg_balance_mode,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [lbsel_pkg::TYPE_W-1:0]    in_req_type,
  input logic [lbsel_pkg::ID_W-1:0]      in_server_id,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [lbsel_pkg::ID_W-1:0]      out_chosen_id,
  input logic [lbsel_pkg::CNT_OUT_W-1:0] out_conn_count,
  input logic [lbsel_pkg::ST_W-1:0]      out_status
);

  // reset leaves no result beat pending
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat pending after reset");

  // one request at a time: busy right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a request is in flight");

  // a failed request names no server
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != lbsel_pkg::ST_OK |->
      out_chosen_id == '0 && out_conn_count == '0)
    else $error("failed request reports a server");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_chosen_id) &&
      $stable(out_conn_count) && $stable(out_status))
    else $error("stalled result beat changed");

endmodule

bind server_load_balancer_selector lbsel_chk u_lbsel_chk (.*);
